// ----- hdl/scw_pkg.sv -----
// ----------------------------------------------------------------------------
// scw_pkg
// Shared widths, limits and types for the shortest coverage window block.
// ----------------------------------------------------------------------------
package scw_pkg;

    // bin store geometry
    localparam int IDX_BITS   = 15;
    localparam int MAX_BINS   = 1 << IDX_BITS;
    localparam int LOAD_BITS  = IDX_BITS + 1;

    // field widths
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = 31;
    localparam int FRAC_BITS  = 16;
    localparam int NEED_BITS  = SUM_BITS + FRAC_BITS;

    // saturation level of the running total
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // coverage fraction after reset, about 0.6827 in Q0.16
    localparam logic [FRAC_BITS-1:0] FRAC_RESET = 16'd44740;

    // write request into the bin store
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   addr;
        logic [COUNT_BITS-1:0] data;
    } t_wr_req;

endpackage

// ----- hdl/scw_ifs.sv -----
// ----------------------------------------------------------------------------
// scw_ifs
// Valid/ready channels of the shortest coverage window block.
// ----------------------------------------------------------------------------

// bin word channel
interface scw_in_if import scw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] bin_count;
    logic                  last_bin;

    modport source (output valid, output bin_count, output last_bin, input ready);
    modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

// coverage fraction write channel
interface scw_cfg_if import scw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result word channel
interface scw_out_if import scw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [IDX_BITS-1:0] low_bin;
    logic [IDX_BITS-1:0] high_bin;
    logic [SUM_BITS-1:0] window_sum;
    logic [IDX_BITS-1:0] width_bins;

    modport source (output valid, output found, output low_bin, output high_bin,
                    output window_sum, output width_bins, input ready);
    modport sink   (input valid, input found, input low_bin, input high_bin,
                    input window_sum, input width_bins, output ready);
endinterface

// ----- hdl/scw_bin_store.sv -----
// ----------------------------------------------------------------------------
// scw_bin_store
// Single-write, single-read bin count memory with registered read data.
// ----------------------------------------------------------------------------
module scw_bin_store import scw_pkg::*; (
    input  logic                  i_clk,
    input  t_wr_req               i_wr,
    input  logic [IDX_BITS-1:0]   i_rd_addr,
    output logic [COUNT_BITS-1:0] o_rd_data
);

    logic [COUNT_BITS-1:0] r_mem [MAX_BINS];
    logic [COUNT_BITS-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/shortest_coverage_window_core.sv -----
// ----------------------------------------------------------------------------
// shortest_coverage_window_core
// Stores histogram bins, then finds the narrowest bin range that holds the
// requested fraction of the total with a two-pointer walk over the store.
//
//   channel   dir  payload                                         handshake
//   i_bin     in   bin_count[16], last_bin                         valid/ready
//   i_cfg     in   data[16] = coverage_fraction (Q0.16)            valid/ready
//   o_win     out  found, low_bin, high_bin, window_sum, width_bins valid/ready
//
// Bins load at one per cycle. After the last bin, the S_NEED state forms the target
// (fraction times total, the only multiplier). Each right-pointer step passes
// through S_CHECK and S_ADD and each left-pointer step through S_CHECK, S_EVAL
// and S_SUB, all sharing the single store read port. i_bin is not ready during the
// walk, nor while a finished result waits behind an occupied output register.
// Reset clears counters and control and loads the fraction register with
// FRAC_RESET; the bin store is not cleared.
// ----------------------------------------------------------------------------
module shortest_coverage_window_core import scw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scw_in_if.sink    i_bin,
    scw_cfg_if.sink   i_cfg,
    scw_out_if.source o_win
);

    // sequencer codes
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_NEED  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_SUB   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [LOAD_BITS-1:0]  r_n, n_n;
    logic [SUM_BITS-1:0]   r_total, n_total;
    logic [NEED_BITS-1:0]  r_need, n_need;
    logic [LOAD_BITS-1:0]  r_l, n_l;
    logic [LOAD_BITS-1:0]  r_r, n_r;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic                  r_have, n_have;
    logic [IDX_BITS-1:0]   r_best_lo, n_best_lo;
    logic [IDX_BITS-1:0]   r_best_hi, n_best_hi;
    logic [IDX_BITS-1:0]   r_best_w, n_best_w;
    logic [SUM_BITS-1:0]   r_best_sum, n_best_sum;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found;
    logic [IDX_BITS-1:0]   r_out_lo, r_out_hi, r_out_w;
    logic [SUM_BITS-1:0]   r_out_sum;

    logic                  w_bin_acc;
    logic                  w_slot_free;
    logic [SUM_BITS:0]     w_total_add;
    logic                  w_meets;
    logic [SUM_BITS-1:0]   w_alu;
    logic [LOAD_BITS-1:0]  w_cand_w;
    logic [IDX_BITS-1:0]   w_rd_addr;
    logic [COUNT_BITS-1:0] w_rd_data;
    logic                  w_load_out;
    t_wr_req               w_wr;

    // handshakes
    assign i_bin.ready = (r_state == S_LOAD);
    assign i_cfg.ready = 1'b1;
    assign w_bin_acc   = i_bin.valid && i_bin.ready;
    assign w_slot_free = !r_out_valid || o_win.ready;

    // bin store
    assign w_wr.en   = w_bin_acc && (r_n < LOAD_BITS'(MAX_BINS));
    assign w_wr.addr = r_n[IDX_BITS-1:0];
    assign w_wr.data = i_bin.bin_count;
    assign w_rd_addr = (r_state == S_EVAL) ? r_l[IDX_BITS-1:0] : r_r[IDX_BITS-1:0];

    scw_bin_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // saturating running total
    assign w_total_add = {1'b0, r_total} + (SUM_BITS+1)'(i_bin.bin_count);

    // shared window sum unit: add on extension, subtract on advance
    assign w_alu = (r_state == S_SUB) ? r_sum - SUM_BITS'(w_rd_data)
                                      : r_sum + SUM_BITS'(w_rd_data);

    // coverage compare: sum * 2^16 >= fraction * total
    assign w_meets  = {r_sum, {FRAC_BITS{1'b0}}} >= r_need;
    assign w_cand_w = r_r - r_l - LOAD_BITS'(1);

    assign w_load_out = (r_state == S_DONE) && w_slot_free;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_total    = r_total;
        n_need     = r_need;
        n_l        = r_l;
        n_r        = r_r;
        n_sum      = r_sum;
        n_have     = r_have;
        n_best_lo  = r_best_lo;
        n_best_hi  = r_best_hi;
        n_best_w   = r_best_w;
        n_best_sum = r_best_sum;
        case (r_state)
            S_LOAD: begin
                if (w_wr.en) begin
                    n_n     = r_n + LOAD_BITS'(1);
                    n_total = w_total_add[SUM_BITS] ? SUM_MAX : w_total_add[SUM_BITS-1:0];
                end
                if (w_bin_acc && i_bin.last_bin) begin
                    n_state = S_NEED;
                end
            end
            S_NEED: begin
                n_need     = NEED_BITS'(r_frac) * NEED_BITS'(r_total);
                n_l        = '0;
                n_r        = '0;
                n_sum      = '0;
                n_have     = 1'b0;
                n_best_lo  = '0;
                n_best_hi  = '0;
                n_best_w   = '0;
                n_best_sum = '0;
                n_state    = (r_n == '0) ? S_DONE : S_CHECK;
            end
            S_CHECK: begin
                // read at the right pointer is issued here when extending
                if ((r_r == r_l) || ((r_r < r_n) && !w_meets)) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_ADD: begin
                n_sum   = w_alu;
                n_r     = r_r + LOAD_BITS'(1);
                n_state = S_CHECK;
            end
            S_EVAL: begin
                // read at the left pointer is issued here
                if (w_meets) begin
                    if (!r_have || (w_cand_w[IDX_BITS-1:0] < r_best_w)) begin
                        n_have     = 1'b1;
                        n_best_w   = w_cand_w[IDX_BITS-1:0];
                        n_best_lo  = r_l[IDX_BITS-1:0];
                        n_best_hi  = w_cand_w[IDX_BITS-1:0] + r_l[IDX_BITS-1:0];
                        n_best_sum = r_sum;
                    end
                    n_state = S_SUB;
                end else begin
                    // right pointer at the end: later windows only shrink
                    n_state = S_DONE;
                end
            end
            S_SUB: begin
                n_sum   = w_alu;
                n_l     = r_l + LOAD_BITS'(1);
                n_state = (r_l + LOAD_BITS'(1) == r_n) ? S_DONE : S_CHECK;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_n     = '0;
                    n_total = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_win.valid && o_win.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= '0;
            r_total     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_frac      <= FRAC_RESET;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_total     <= n_total;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_frac <= i_cfg.data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_l        <= n_l;
        r_r        <= n_r;
        r_sum      <= n_sum;
        r_best_lo  <= n_best_lo;
        r_best_hi  <= n_best_hi;
        r_best_w   <= n_best_w;
        r_best_sum <= n_best_sum;
        if (w_load_out) begin
            r_out_found <= r_have;
            r_out_lo    <= r_best_lo;
            r_out_hi    <= r_best_hi;
            r_out_sum   <= r_best_sum;
            r_out_w     <= r_best_hi - r_best_lo;
        end
    end

    // result word
    assign o_win.valid      = r_out_valid;
    assign o_win.found      = r_out_found;
    assign o_win.low_bin    = r_out_lo;
    assign o_win.high_bin   = r_out_hi;
    assign o_win.window_sum = r_out_sum;
    assign o_win.width_bins = r_out_w;

endmodule
